// ===== rtl/scs_pkg.sv =====
`default_nettype none

package scs_pkg;

   localparam int LineBitsDefault = 20;
   localparam int LineFieldBits   = 20;
   localparam int QueueDepth      = 4;

   localparam logic [7:0] CharNl     = 8'h0A;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharDquote = 8'h22;
   localparam logic [7:0] CharHash   = 8'h23;
   localparam logic [7:0] CharSquote = 8'h27;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharSlash  = 8'h2F;
   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharDel    = 8'h7F;

   localparam logic OpByte = 1'b0;
   localparam logic OpEnd  = 1'b1;

   typedef enum logic [3:0] {
      MODE_CODE      = 4'd0,
      MODE_SLASH     = 4'd1,
      MODE_LINE_CMT  = 4'd2,
      MODE_BLOCK_CMT = 4'd3,
      MODE_STR       = 4'd4,
      MODE_STR_ESC   = 4'd5,
      MODE_CHR_FIRST = 4'd6,
      MODE_CHR_ESC   = 4'd7,
      MODE_CHR_CLOSE = 4'd8
   } mode_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]               out_byte;
      logic                     bad_char;
      logic [LineFieldBits-1:0] line_number;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      mode_type mode;
      logic     skip_space;
      logic     saw_star;
      logic     halted;
   } lex_state_type;

   // up to two results produced by one beat
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } res_pair_type;

   localparam lex_state_type LexReset = '{
      mode:       MODE_CODE,
      skip_space: 1'b1,
      saw_star:   1'b0,
      halted:     1'b0
   };

endpackage

`default_nettype wire

// ===== rtl/source_comment_stripper.sv =====
// source_comment_stripper: strips comments and redundant white space from C source.
// req channel: one beat per source byte (operation = 0) or an end marker
// (operation = 1) that flushes a pending slash and returns the lexer to its
// start state. rsp channel: zero, one or two result beats per request beat,
// the final one of each request marked by last. A byte of 128 or above in
// code gives one result with bad_char set; bytes are then ignored until the
// end marker.
// Each result is written into the queue when its request is taken and is offered
// on rsp from there. Throughput: one request per cycle while each yields at most
// one result and the receiver takes results; a slash followed by an ordinary
// byte yields two results, which leave the queue one at a time. Results wait in
// a four-entry queue, and req_ready drops while more than two entries are
// occupied, so a stalled receiver holds back the sender without losing results.
// Reset (synchronous, active high) empties the queue, sets the line count to
// one and puts the lexer in code mode with leading spaces suppressed.
`default_nettype none

module source_comment_stripper #(
   parameter int LINE_BITS = scs_pkg::LineBitsDefault
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire scs_pkg::req_type  req,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output scs_pkg::rsp_type       rsp
);

   scs_pkg::lex_state_type st_ff;
   scs_pkg::lex_state_type st_in;
   logic [LINE_BITS-1:0]   line_ff;
   logic [LINE_BITS-1:0]   line_in;
   scs_pkg::res_pair_type  res;
   logic                   accept;

   assign accept = req_valid && req_ready;

   scs_lexer #(
      .LINE_BITS (LINE_BITS)
   ) u_lexer (
      .req       (req),
      .st_cur    (st_ff),
      .line_cur  (line_ff),
      .st_next   (st_in),
      .line_next (line_in),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= scs_pkg::LexReset;
         line_ff <= LINE_BITS'(1);
      end else if (accept) begin
         st_ff   <= st_in;
         line_ff <= line_in;
      end
   end

   scs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .res       (res),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp),
      .room      (req_ready)
   );

endmodule

`default_nettype wire

// ===== rtl/scs_lexer.sv =====
`default_nettype none

module scs_lexer #(
   parameter int LINE_BITS = scs_pkg::LineBitsDefault
) (
   input  wire scs_pkg::req_type       req,
   input  wire scs_pkg::lex_state_type st_cur,
   input  wire [LINE_BITS-1:0]         line_cur,
   output scs_pkg::lex_state_type      st_next,
   output logic [LINE_BITS-1:0]        line_next,
   output scs_pkg::res_pair_type       res
);

   localparam logic [LINE_BITS-1:0] LineMax = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LineOne = LINE_BITS'(1);

   logic                 bump;
   logic [LINE_BITS-1:0] line_rep;
   logic [7:0]           b;
   logic [7:0]           cb;
   logic [7:0]           b0;
   logic [7:0]           b1;
   logic                 bad0;
   logic [1:0]           n;

   assign b = req.in_byte;

   always_comb begin
      bump = (req.operation == scs_pkg::OpByte) && !st_cur.halted && (b == scs_pkg::CharNl);
      if (bump && line_cur != LineMax) begin
         line_rep = line_cur + LineOne;
      end else begin
         line_rep = line_cur;
      end
   end

   always_comb begin
      st_next = st_cur;
      n       = 2'd0;
      b0      = b;
      b1      = b;
      bad0    = 1'b0;
      cb      = b;
      if (req.operation == scs_pkg::OpEnd) begin
         if (!st_cur.halted && st_cur.mode == scs_pkg::MODE_SLASH) begin
            n  = 2'd1;
            b0 = scs_pkg::CharSlash;
         end
         st_next = scs_pkg::LexReset;
      end else if (!st_cur.halted) begin
         case (st_cur.mode)
            scs_pkg::MODE_SLASH: begin
               if (b == scs_pkg::CharSlash) begin
                  st_next.mode = scs_pkg::MODE_LINE_CMT;
               end else if (b == scs_pkg::CharStar) begin
                  st_next.saw_star = 1'b0;
                  st_next.mode     = scs_pkg::MODE_BLOCK_CMT;
               end else begin
                  n            = 2'd2;
                  b0           = scs_pkg::CharSlash;
                  b1           = b;
                  st_next.mode = scs_pkg::MODE_CODE;
               end
            end
            scs_pkg::MODE_LINE_CMT: begin
               if (b == scs_pkg::CharNl) begin
                  n            = 2'd1;
                  st_next.mode = scs_pkg::MODE_CODE;
               end
            end
            scs_pkg::MODE_BLOCK_CMT: begin
               if (st_cur.saw_star && b == scs_pkg::CharSlash) begin
                  st_next.mode     = scs_pkg::MODE_CODE;
                  st_next.saw_star = 1'b0;
               end else begin
                  if (b == scs_pkg::CharNl) begin
                     n = 2'd1;
                  end
                  st_next.saw_star = (b == scs_pkg::CharStar);
               end
            end
            scs_pkg::MODE_STR: begin
               n = 2'd1;
               if (b == scs_pkg::CharBslash) begin
                  st_next.mode = scs_pkg::MODE_STR_ESC;
               end else if (b == scs_pkg::CharDquote) begin
                  st_next.mode = scs_pkg::MODE_CODE;
               end
            end
            scs_pkg::MODE_STR_ESC: begin
               n            = 2'd1;
               st_next.mode = scs_pkg::MODE_STR;
            end
            scs_pkg::MODE_CHR_FIRST: begin
               n            = 2'd1;
               st_next.mode = (b == scs_pkg::CharBslash) ? scs_pkg::MODE_CHR_ESC
                                                         : scs_pkg::MODE_CHR_CLOSE;
            end
            scs_pkg::MODE_CHR_ESC: begin
               n            = 2'd1;
               st_next.mode = scs_pkg::MODE_CHR_CLOSE;
            end
            scs_pkg::MODE_CHR_CLOSE: begin
               n            = 2'd1;
               b0           = scs_pkg::CharSquote;
               st_next.mode = scs_pkg::MODE_CODE;
            end
            default: begin
               // code mode
               if (b[7]) begin
                  n              = 2'd1;
                  bad0           = 1'b1;
                  st_next.halted = 1'b1;
               end else begin
                  if (b != scs_pkg::CharNl &&
                      (b < scs_pkg::CharSpace || b == scs_pkg::CharDel)) begin
                     cb = scs_pkg::CharSpace;
                  end
                  if (!(cb == scs_pkg::CharSpace && st_cur.skip_space)) begin
                     st_next.skip_space = (cb == scs_pkg::CharSpace) ||
                                          (cb == scs_pkg::CharHash) ||
                                          (cb == scs_pkg::CharSlash);
                     if (cb == scs_pkg::CharSlash) begin
                        st_next.mode = scs_pkg::MODE_SLASH;
                     end else begin
                        n  = 2'd1;
                        b0 = cb;
                        if (cb == scs_pkg::CharDquote) begin
                           st_next.mode = scs_pkg::MODE_STR;
                        end else if (cb == scs_pkg::CharSquote) begin
                           st_next.mode = scs_pkg::MODE_CHR_FIRST;
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   assign line_next = (req.operation == scs_pkg::OpEnd) ? LineOne : line_rep;

   always_comb begin
      res.cnt            = n;
      res.r0.out_byte    = b0;
      res.r0.bad_char    = bad0;
      res.r0.line_number = scs_pkg::LineFieldBits'(line_rep);
      res.r0.last        = (n == 2'd1);
      res.r1.out_byte    = b1;
      res.r1.bad_char    = 1'b0;
      res.r1.line_number = scs_pkg::LineFieldBits'(line_rep);
      res.r1.last        = 1'b1;
   end

endmodule

`default_nettype wire

// ===== rtl/scs_rsp_queue.sv =====
`default_nettype none

module scs_rsp_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  wire scs_pkg::res_pair_type  res,
   input  wire                         pop,
   output logic                        out_valid,
   output scs_pkg::rsp_type            out_data,
   output logic                        room
);

   localparam int Depth   = scs_pkg::QueueDepth;
   localparam int PtrBits = $clog2(Depth);
   localparam int CntBits = $clog2(Depth + 1);

   scs_pkg::rsp_type     mem_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff;
   logic [PtrBits-1:0]   wr_ptr_in;
   logic [PtrBits-1:0]   wr_ptr_nx;
   logic [PtrBits-1:0]   rd_ptr_ff;
   logic [PtrBits-1:0]   rd_ptr_in;
   logic [CntBits-1:0]   count_ff;
   logic [CntBits-1:0]   count_in;
   logic [1:0]           n_push;
   logic                 do_pop;

   assign n_push    = push ? res.cnt : 2'd0;
   assign do_pop    = pop && (count_ff != '0);
   assign wr_ptr_nx = wr_ptr_ff + PtrBits'(1);
   assign wr_ptr_in = wr_ptr_ff + PtrBits'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PtrBits'(do_pop);
   assign count_in  = count_ff + CntBits'(n_push) - CntBits'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= res.r0;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_nx] <= res.r1;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   // a beat may push two results, so keep two free slots
   assign room      = (count_ff <= CntBits'(Depth - 2));

endmodule

`default_nettype wire

// ===== rtl/scs_checker.sv =====
`default_nettype none

module scs_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input wire scs_pkg::req_type  req,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire scs_pkg::rsp_type  rsp
);

   // a waiting request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req))
      else $error("req beat changed while waiting");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp beat changed while stalled");

   // the first of a pair is always followed by its partner
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last |=> rsp_valid)
      else $error("second result of a pair missing");

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.bad_char |-> rsp.last && rsp.out_byte[7])
      else $error("error result malformed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("results present after reset");

endmodule

bind source_comment_stripper scs_checker u_scs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

`default_nettype wire
